// ===== hw/rtl/pls_pkg.sv =====
// Package: shared constants, types and cell control for the positional list store.
package pls_pkg;

   localparam int DEPTH  = 128;
   localparam int ITEM_W = 32;
   localparam int POS_W  = 7;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int OUT_CNT_W = 8;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_APPEND = 2'd1,
      OP_DELETE = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_FULL   = 2'd1,
      STAT_BADPOS = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

   typedef struct packed {
      logic             ins;
      logic             app;
      logic             del;
      logic             load;
      logic             shift;
      logic [CMP_W-1:0] pos;
      logic [CMP_W-1:0] held;
   } cell_ctl_type;

endpackage

// ===== hw/rtl/pls_cell.sv =====
// One list cell: a stored slot plus a pick register that shifts toward the front.
module pls_cell (
   input  logic                             clock,
   input  pls_pkg::cell_ctl_type            ctl,
   input  logic [pls_pkg::CMP_W-1:0]        idx,
   input  logic signed [pls_pkg::ITEM_W-1:0] item,
   input  logic signed [pls_pkg::ITEM_W-1:0] left_slot,
   input  logic signed [pls_pkg::ITEM_W-1:0] right_slot,
   input  logic signed [pls_pkg::ITEM_W-1:0] right_pick,
   output logic signed [pls_pkg::ITEM_W-1:0] slot,
   output logic signed [pls_pkg::ITEM_W-1:0] pick
);

   logic signed [pls_pkg::ITEM_W-1:0] slot_ff, slot_in;
   logic signed [pls_pkg::ITEM_W-1:0] pick_ff, pick_in;
   logic eq_pos, gt_pos, eq_held;

   always_comb begin
      eq_pos  = (idx == ctl.pos);
      gt_pos  = (idx > ctl.pos);
      eq_held = (idx == ctl.held);
      slot_in = slot_ff;
      if (ctl.ins) begin
         if (eq_pos) begin
            slot_in = item;
         end else if (gt_pos) begin
            slot_in = left_slot;
         end
      end else if (ctl.app) begin
         if (eq_held) begin
            slot_in = item;
         end
      end else if (ctl.del) begin
         if (eq_pos || gt_pos) begin
            slot_in = right_slot;
         end
      end
      pick_in = pick_ff;
      if (ctl.load) begin
         pick_in = slot_ff;
      end else if (ctl.shift) begin
         pick_in = right_pick;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      pick_ff <= pick_in;
   end

   assign slot = slot_ff;
   assign pick = pick_ff;

endmodule

// ===== hw/rtl/positional_list_store.sv =====
// Top level: positional list store built as a chain of cells with a request sequencer.
// Insert, append and any error: result staged in the cycle after accept, then moved to rsp once rsp is free.
// Read and delete: the picked item shifts to the front while the scan counts pos down to zero, then is staged.
// A new word is accepted once the staged result has moved to rsp (rsp may still hold one word).
// Shifting for insert and delete is done in the accept cycle by the cells from pos to the back.
// Synchronous active-high reset empties the list; slot contents are not cleared.
module positional_list_store (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // pos[6:0], item[38:7], zero pad
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // data[31:0], count[39:32]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   localparam int DEPTH  = pls_pkg::DEPTH;
   localparam int ITEM_W = pls_pkg::ITEM_W;
   localparam int POS_W  = pls_pkg::POS_W;
   localparam int CNT_W  = pls_pkg::CNT_W;
   localparam int CMP_W  = pls_pkg::CMP_W;
   localparam int OCW    = pls_pkg::OUT_CNT_W;

   pls_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   held_ff, held_in;
   logic [POS_W-1:0]   cnt_ff, cnt_in;

   logic                      res_valid_ff, res_valid_in;
   logic signed [ITEM_W-1:0]  res_data_ff, res_data_in;
   pls_pkg::status_type       res_status_ff, res_status_in;
   logic [OCW-1:0]            res_count_ff, res_count_in;

   logic                      rsp_valid_ff;
   logic signed [ITEM_W-1:0]  rsp_data_ff;
   pls_pkg::status_type       rsp_status_ff;
   logic [OCW-1:0]            rsp_count_ff;

   pls_pkg::cell_ctl_type     ctl;
   logic                      accept, rsp_load, full;
   logic [POS_W-1:0]          req_pos;
   logic signed [ITEM_W-1:0]  req_item;
   logic [CMP_W-1:0]          pos_x, held_x;

   logic signed [ITEM_W-1:0]  slot_w [DEPTH];
   logic signed [ITEM_W-1:0]  pick_w [DEPTH];
   logic signed [ITEM_W-1:0]  left_w [DEPTH];
   logic signed [ITEM_W-1:0]  right_w [DEPTH];
   logic signed [ITEM_W-1:0]  rpick_w [DEPTH];

   assign req_pos  = req_tdata[6:0];
   assign req_item = req_tdata[38:7];
   assign pos_x    = CMP_W'(req_pos);
   assign held_x   = CMP_W'(held_ff);
   assign full     = (held_ff == CNT_W'(DEPTH));
   assign accept   = req_tvalid && req_tready;
   assign rsp_load = res_valid_ff && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      req_tready    = (state_ff == pls_pkg::ST_IDLE) && !res_valid_ff;
      state_in      = state_ff;
      held_in       = held_ff;
      cnt_in        = cnt_ff;
      res_valid_in  = res_valid_ff && !rsp_load;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      res_count_in  = res_count_ff;
      ctl           = '0;
      ctl.pos       = pos_x;
      ctl.held      = held_x;
      unique case (state_ff)
         pls_pkg::ST_IDLE: begin
            if (accept) begin
               res_data_in   = '0;
               res_status_in = pls_pkg::STAT_OK;
               res_valid_in  = 1'b1;
               unique case (pls_pkg::op_type'(req_tuser))
                  pls_pkg::OP_INSERT: begin
                     if (full) begin
                        res_status_in = pls_pkg::STAT_FULL;
                     end else if (pos_x > held_x) begin
                        res_status_in = pls_pkg::STAT_BADPOS;
                     end else begin
                        ctl.ins = 1'b1;
                        held_in = CNT_W'(held_ff + 1'b1);
                     end
                  end
                  pls_pkg::OP_APPEND: begin
                     if (full) begin
                        res_status_in = pls_pkg::STAT_FULL;
                     end else begin
                        ctl.app = 1'b1;
                        held_in = CNT_W'(held_ff + 1'b1);
                     end
                  end
                  pls_pkg::OP_DELETE: begin
                     if (pos_x >= held_x) begin
                        res_status_in = pls_pkg::STAT_BADPOS;
                     end else begin
                        ctl.del      = 1'b1;
                        ctl.load     = 1'b1;
                        held_in      = CNT_W'(held_ff - 1'b1);
                        res_valid_in = 1'b0;
                        cnt_in       = req_pos;
                        state_in     = pls_pkg::ST_SCAN;
                     end
                  end
                  pls_pkg::OP_READ: begin
                     if (pos_x >= held_x) begin
                        res_status_in = pls_pkg::STAT_BADPOS;
                     end else begin
                        ctl.load     = 1'b1;
                        res_valid_in = 1'b0;
                        cnt_in       = req_pos;
                        state_in     = pls_pkg::ST_SCAN;
                     end
                  end
               endcase
               res_count_in = OCW'(held_in);
            end
         end
         pls_pkg::ST_SCAN: begin
            if (cnt_ff == '0) begin
               res_data_in  = pick_w[0];
               res_valid_in = 1'b1;
               state_in     = pls_pkg::ST_IDLE;
            end else begin
               ctl.shift = 1'b1;
               cnt_in    = POS_W'(cnt_ff - 1'b1);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pls_pkg::ST_IDLE;
         held_ff      <= '0;
         res_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         res_valid_ff <= res_valid_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      res_count_ff  <= res_count_in;
      if (rsp_load) begin
         rsp_data_ff   <= res_data_ff;
         rsp_status_ff <= res_status_ff;
         rsp_count_ff  <= res_count_ff;
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_link
      if (g == 0) begin : g_front
         assign left_w[g] = '0;
      end else begin : g_mid
         assign left_w[g] = slot_w[g-1];
      end
      if (g == DEPTH - 1) begin : g_back
         assign right_w[g] = '0;
         assign rpick_w[g] = '0;
      end else begin : g_inner
         assign right_w[g] = slot_w[g+1];
         assign rpick_w[g] = pick_w[g+1];
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      pls_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .idx        (CMP_W'(g)),
         .item       (req_item),
         .left_slot  (left_w[g]),
         .right_slot (right_w[g]),
         .right_pick (rpick_w[g]),
         .slot       (slot_w[g]),
         .pick       (pick_w[g])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_data_ff};
   assign rsp_tuser  = rsp_status_ff;

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CNT_W'(DEPTH))
      else $error("item count above depth");

   a_no_accept_in_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == pls_pkg::ST_SCAN |-> !req_tready)
      else $error("word accepted during scan");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (res_valid_ff || state_ff == pls_pkg::ST_SCAN))
      else $error("accepted word produced no result and no scan");

   a_scan_no_count_change: assert property (@(posedge clock) disable iff (reset)
      state_ff == pls_pkg::ST_SCAN |=> held_ff == $past(held_ff))
      else $error("count changed during scan");

endmodule

// ===== dv/pls_list_checker.sv =====
// Checker for the positional list store: mirrors the list, predicts each result word and compares.
module pls_list_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // pos[6:0], item[38:7], zero pad
   input  logic [1:0]  req_tuser,   // op[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // data[31:0], count[39:32]
   input  logic [1:0]  rsp_tuser,   // status[1:0]
   output int          fail_count,
   output int          pending
);

   typedef struct {
      logic signed [pls_pkg::ITEM_W-1:0] data;
      pls_pkg::status_type               status;
      logic [pls_pkg::OUT_CNT_W-1:0]     count;
   } list_rsp_type;

   logic signed [pls_pkg::ITEM_W-1:0] list_items[$];
   list_rsp_type                      rsp_due[$];

   function automatic list_rsp_type apply_list_op(pls_pkg::op_type op, int pos,
                                                  logic signed [pls_pkg::ITEM_W-1:0] item);
      list_rsp_type r;
      r.data   = '0;
      r.status = pls_pkg::STAT_OK;
      case (op)
         pls_pkg::OP_INSERT: begin
            if (list_items.size() >= pls_pkg::DEPTH)
               r.status = pls_pkg::STAT_FULL;
            else if (pos > list_items.size())
               r.status = pls_pkg::STAT_BADPOS;
            else
               list_items.insert(pos, item);
         end
         pls_pkg::OP_APPEND: begin
            if (list_items.size() >= pls_pkg::DEPTH)
               r.status = pls_pkg::STAT_FULL;
            else
               list_items.push_back(item);
         end
         pls_pkg::OP_DELETE: begin
            if (pos >= list_items.size()) begin
               r.status = pls_pkg::STAT_BADPOS;
            end else begin
               r.data = list_items[pos];
               list_items.delete(pos);
            end
         end
         default: begin
            if (pos >= list_items.size())
               r.status = pls_pkg::STAT_BADPOS;
            else
               r.data = list_items[pos];
         end
      endcase
      r.count = pls_pkg::OUT_CNT_W'(list_items.size());
      return r;
   endfunction

   always @(posedge clock) begin
      list_rsp_type got;
      list_rsp_type want;
      if (reset) begin
         list_items.delete();
         rsp_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.data   = rsp_tdata[31:0];
            got.status = pls_pkg::status_type'(rsp_tuser);
            got.count  = rsp_tdata[39:32];
            if (rsp_due.size() == 0) begin
               $display("%0t: unexpected word: data %0d status %0d count %0d",
                        $time, got.data, got.status, got.count);
               fail_count++;
            end else begin
               want = rsp_due.pop_front();
               if (got.data !== want.data) begin
                  $display("%0t: data mismatch: expected %0d got %0d",
                           $time, want.data, got.data);
                  fail_count++;
               end
               if (got.status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d got %0d",
                           $time, want.status, got.status);
                  fail_count++;
               end
               if (got.count !== want.count) begin
                  $display("%0t: count mismatch: expected %0d got %0d",
                           $time, want.count, got.count);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            rsp_due.push_back(apply_list_op(pls_pkg::op_type'(req_tuser),
                                            int'(req_tdata[6:0]),
                                            $signed(req_tdata[38:7])));
      end
      pending = rsp_due.size();
   end

endmodule

// ===== dv/tb_positional_list_store.sv =====
// Testbench top for the positional list store: request stimulus, result backpressure, verdict.
module tb_positional_list_store;

   localparam int IDLE_LIMIT   = 3000;
   localparam int LONG_HOLD    = 300;
   localparam int RANDOM_WORDS = 1100;
   localparam int DRAIN_WAIT   = 200;

   typedef enum {MODE_GROW, MODE_MIXED, MODE_SHRINK} phase_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   int fail_count;
   int pending;
   int idle_cycles = 0;
   int list_len    = 0;
   bit no_idle     = 1'b0;
   int hold_req    = 0;
   int hold_done   = 0;

   positional_list_store uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   pls_list_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_positional_list_store NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_req != hold_done) begin
            stall     = LONG_HOLD;
            hold_done = hold_req;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, 11);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   task automatic send_word(pls_pkg::op_type op, int pos, logic signed [31:0] item);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, item, pos[6:0]};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      case (op)
         pls_pkg::OP_INSERT: if (list_len < pls_pkg::DEPTH && pos <= list_len) list_len++;
         pls_pkg::OP_APPEND: if (list_len < pls_pkg::DEPTH) list_len++;
         pls_pkg::OP_DELETE: if (pos < list_len) list_len--;
         default: ;
      endcase
   endtask

   task automatic drain_rsp();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   function automatic pls_pkg::op_type pick_op(phase_mode_type mode);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         MODE_GROW:
            return r < 45 ? pls_pkg::OP_INSERT : r < 85 ? pls_pkg::OP_APPEND :
                   r < 90 ? pls_pkg::OP_DELETE : pls_pkg::OP_READ;
         MODE_SHRINK:
            return r < 5 ? pls_pkg::OP_INSERT : r < 10 ? pls_pkg::OP_APPEND :
                   r < 80 ? pls_pkg::OP_DELETE : pls_pkg::OP_READ;
         default:
            return pls_pkg::op_type'(r % 4);
      endcase
   endfunction

   function automatic int pick_pos(pls_pkg::op_type op);
      if (op == pls_pkg::OP_APPEND || $urandom_range(0, 9) == 0)
         return $urandom_range(0, 127);
      if (op == pls_pkg::OP_INSERT)
         return $urandom_range(0, list_len < 127 ? list_len : 127);
      if (list_len == 0)
         return $urandom_range(0, 127);
      return $urandom_range(0, list_len - 1);
   endfunction

   function automatic logic signed [31:0] pick_item();
      case ($urandom_range(0, 15))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      phase_mode_type  mode;
      pls_pkg::op_type op;
      int              random_sent;
      int              phase_words;
      int              at_edge;
      int              phase_idx;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty list, bad positions, front/back/middle insert and delete
      send_word(pls_pkg::OP_READ, 0, 0);
      send_word(pls_pkg::OP_DELETE, 0, 0);
      send_word(pls_pkg::OP_READ, 127, 0);
      send_word(pls_pkg::OP_INSERT, 1, 32'sd5);
      send_word(pls_pkg::OP_INSERT, 0, 32'sh7FFF_FFFF);
      send_word(pls_pkg::OP_APPEND, 99, 32'sh8000_0000);
      send_word(pls_pkg::OP_INSERT, 2, -32'sd1);
      send_word(pls_pkg::OP_INSERT, 1, 32'sd0);
      send_word(pls_pkg::OP_INSERT, 0, 32'sh5A5A_A5A5);
      for (int i = 0; i < 6; i++)
         send_word(pls_pkg::OP_READ, i, 0);
      send_word(pls_pkg::OP_DELETE, 4, 0);
      send_word(pls_pkg::OP_DELETE, 0, 0);
      send_word(pls_pkg::OP_DELETE, 1, 0);
      send_word(pls_pkg::OP_INSERT, 127, 32'sd7);
      send_word(pls_pkg::OP_DELETE, 127, 0);
      send_word(pls_pkg::OP_READ, 127, 0);
      send_word(pls_pkg::OP_APPEND, 0, 32'sd1);

      random_sent = 0;
      phase_idx   = 0;
      while (random_sent < RANDOM_WORDS) begin
         drain_rsp();
         mode    = phase_mode_type'(phase_idx % 3);
         no_idle = ($urandom_range(0, 3) == 0);
         if (mode == MODE_MIXED)
            hold_req++;
         phase_words = 0;
         at_edge     = 0;
         while (random_sent < RANDOM_WORDS) begin
            op = pick_op(mode);
            send_word(op, pick_pos(op), pick_item());
            phase_words++;
            random_sent++;
            if ((mode == MODE_GROW && list_len == pls_pkg::DEPTH) ||
                (mode == MODE_SHRINK && list_len == 0))
               at_edge++;
            if (at_edge >= 30 || phase_words >= (mode == MODE_MIXED ? 100 : 300))
               break;
         end
         phase_idx++;
      end

      drain_rsp();
      repeat (DRAIN_WAIT) @(negedge clock);
      if (fail_count == 0)
         $display("tb_positional_list_store OK");
      else
         $display("tb_positional_list_store NOT OK");
      $finish;
   end

endmodule
